@@ hw/rtl/dnc_pkg.sv @@
// Shared widths, constants and stage payload types for the date / day number
// converter. No dependencies.
`timescale 1ns / 1ps

package dnc_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DN_W    = 22;
	localparam int BASE_W  = 23;   // days before a year, 14-bit year range
	localparam int REM_W   = 24;   // signed remainder after year removal
	localparam int DOY_W   = 9;    // day of year 0..366

	localparam logic [DN_W-1:0] DN_MAX = '1;

	// year estimate: floor(n * 400 / 146097) = (n * YEAR_RECIP) >> YEAR_RECIP_SHIFT,
	// reciprocal rounded up, exact over the whole 22-bit range
	localparam int               YEAR_RECIP_SHIFT = 40;
	localparam int               YEAR_RECIP_W     = 32;
	localparam logic [YEAR_RECIP_W-1:0] YEAR_RECIP = 32'd3010360590;

	localparam logic FUNC_TO_DN   = 1'b0;
	localparam logic FUNC_TO_DATE = 1'b1;

	// operands after the input register
	typedef struct packed {
		logic                 func;
		logic [YEAR_W-1:0]    year;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day;
		logic [DN_W-1:0]      num;
	} dnc_in_t;

	// after the year estimate: year holds the selected year for either func
	typedef dnc_in_t dnc_s2_t;

	// after the year base stage
	typedef struct packed {
		dnc_s2_t              op;
		logic [BASE_W-1:0]    base;
		logic                 leap_cur;
		logic                 leap_next;
	} dnc_s3_t;

	typedef struct packed {
		logic [DN_W-1:0]      day_number;
		logic [YEAR_W-1:0]    year;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day;
		logic                 valid;
	} dnc_res_t;

endpackage

@@ hw/rtl/dnc_year_est.sv @@
// Year estimate from a day number by reciprocal multiply; selects the year
// that the following stages work on. Depends on dnc_pkg.
`timescale 1ns / 1ps

module dnc_year_est import dnc_pkg::*; (
	input  dnc_in_t op,
	output dnc_s2_t res
);

	localparam int PROD_W = DN_W + YEAR_RECIP_W;

	logic [PROD_W-1:0] prod;
	logic [YEAR_W-1:0] y_est;

	assign prod  = PROD_W'(op.num) * PROD_W'(YEAR_RECIP);
	assign y_est = prod[YEAR_RECIP_SHIFT +: YEAR_W];

	always_comb begin
		res = op;
		if (op.func == FUNC_TO_DATE) begin
			res.year = y_est;
		end
	end

endmodule

@@ hw/rtl/dnc_year_base.sv @@
// Days before a year and leap flags for that year and the next.
// Depends on dnc_pkg.
`timescale 1ns / 1ps

module dnc_year_base import dnc_pkg::*; (
	input  dnc_s2_t op,
	output dnc_s3_t res
);

	// floor(x / 25) for x < 4681 by reciprocal 2622 / 2^16
	function automatic logic [7:0] div25(input logic [11:0] x);
		logic [27:0] prod;
		prod = 28'(x) * 28'd2622;
		return prod[23:16];
	endfunction

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [11:0] q4;
		logic [11:0] q16;
		logic        by100;
		logic        by400;
		q4    = y[YEAR_W-1:2];
		q16   = {2'b00, y[YEAR_W-1:4]};
		by100 = (q4 == 12'(div25(q4)) * 12'd25);
		by400 = (y[3:0] == 4'd0) && (q16 == 12'(div25(q16)) * 12'd25);
		return (y[1:0] == 2'd0) && (!by100 || by400);
	endfunction

	logic [YEAR_W-1:0] p;
	logic [11:0]       p4;
	logic [11:0]       p16;

	assign p   = (op.year == '0) ? '0 : op.year - YEAR_W'(1);
	assign p4  = p[YEAR_W-1:2];
	assign p16 = {2'b00, p[YEAR_W-1:4]};

	always_comb begin
		res.op        = op;
		res.base      = BASE_W'(op.year) * BASE_W'(365) + BASE_W'(p4)
		              - BASE_W'(div25(p4)) + BASE_W'(div25(p16));
		res.leap_cur  = is_leap(op.year);
		res.leap_next = is_leap(op.year + YEAR_W'(1));
	end

endmodule

@@ hw/rtl/dnc_finish.sv @@
// Final stage: day number sum for func 0, remainder correction and month
// search for func 1. Depends on dnc_pkg.
`timescale 1ns / 1ps

module dnc_finish import dnc_pkg::*; (
	input  dnc_s3_t  op,
	output dnc_res_t res
);

	function automatic logic [DOY_W-1:0] days_before(input logic leap,
	                                                 input logic [MONTH_W-1:0] idx);
		logic [DOY_W-1:0] d;
		case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			4'd12:   d = 9'd365;
			default: d = 9'd0;
		endcase
		if (leap && idx >= 4'd2 && idx <= 4'd12) begin
			d = d + 9'd1;
		end
		return d;
	endfunction

	logic [BASE_W-1:0]       total;
	logic signed [REM_W-1:0] rem0;
	logic signed [REM_W-1:0] rem1;
	logic signed [REM_W-1:0] ylen;
	logic [YEAR_W-1:0]       y1;
	logic                    kind;
	logic [DOY_W-1:0]        doy;
	logic [DOY_W-1:0]        prev;
	logic [MONTH_W-1:0]      mon;

	always_comb begin
		res   = '0;
		total = BASE_W'(op.op.day) + op.base
		      + BASE_W'(days_before(op.leap_cur, op.op.month - MONTH_W'(1)));
		rem0  = $signed(REM_W'(op.op.num)) - $signed(REM_W'(op.base));
		ylen  = op.leap_cur ? REM_W'(366) : REM_W'(365);
		rem1  = rem0;
		y1    = op.op.year;
		kind  = op.leap_cur;
		if (rem0 > ylen) begin
			rem1 = rem0 - ylen;
			y1   = op.op.year + YEAR_W'(1);
			kind = op.leap_next;
		end
		doy  = rem1[DOY_W-1:0];
		mon  = MONTH_W'(1);
		prev = '0;
		for (int k = 1; k < 12; k++) begin
			if (days_before(kind, MONTH_W'(k)) < doy) begin
				mon  = MONTH_W'(k + 1);
				prev = days_before(kind, MONTH_W'(k));
			end
		end

		if (op.op.func == FUNC_TO_DN) begin
			if (op.op.month inside {[4'd1:4'd12]}) begin
				if (total > BASE_W'(DN_MAX)) begin
					res.day_number = DN_MAX;
				end else begin
					res.day_number = total[DN_W-1:0];
					res.valid      = 1'b1;
				end
			end
		end else begin
			// non-positive remainder or beyond the year: no date
			if (rem1 > 0 && rem1 <= $signed(REM_W'(days_before(kind, MONTH_W'(12))))) begin
				res.year  = y1;
				res.month = mon;
				res.day   = DAY_W'(doy - prev);
				res.valid = 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/date_day_number_converter_top.sv @@
// Date / day number converter, four-register pipeline.
// An accepted item moves through the input, year estimate and year base registers into the result register.
// Throughput: one item per cycle; each stage holds one item and stalls only
// when the stage after it is full and stalled, so while a result waits the
// input keeps flowing until the three stages behind it are full.
// Reset clears all stage valid flags; no clearing pass.
`timescale 1ns / 1ps

module date_day_number_converter_top import dnc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               req_valid,
	output logic               req_ready,
	input  logic               func,
	input  logic [YEAR_W-1:0]  year_in,
	input  logic [MONTH_W-1:0] month_in,
	input  logic [DAY_W-1:0]   day_in,
	input  logic [DN_W-1:0]    day_number_in,

	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [DN_W-1:0]    day_number_out,
	output logic [YEAR_W-1:0]  year_out,
	output logic [MONTH_W-1:0] month_out,
	output logic [DAY_W-1:0]   day_out,
	output logic               valid_res
);

	// stage valid flags and payload registers
	logic     v1_q, v2_q, v3_q, vo_q;
	dnc_in_t  op_s1;
	dnc_s2_t  op_s2;
	dnc_s3_t  op_s3;
	dnc_res_t res_q;

	// combinational stage outputs
	dnc_s2_t  est_d;
	dnc_s3_t  base_d;
	dnc_res_t fin_d;

	// a stage may load when it is empty or its content moves on this cycle
	logic en1, en2, en3, eno;

	assign eno = !vo_q || rsp_ready;
	assign en3 = !v3_q || eno;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;

	assign req_ready = en1;

	// stage A: year estimate for day number items
	dnc_year_est u_est (
		.op  (op_s1),
		.res (est_d)
	);

	// stage B: days before the year, leap flags
	dnc_year_base u_base (
		.op  (op_s2),
		.res (base_d)
	);

	// stage C: final sum or month search
	dnc_finish u_fin (
		.op  (op_s3),
		.res (fin_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1) v1_q <= req_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (eno) vo_q <= v3_q;
		end
	end

	// payload: no reset, qualified by the valid flags
	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			op_s1.func  <= func;
			op_s1.year  <= year_in;
			op_s1.month <= month_in;
			op_s1.day   <= day_in;
			op_s1.num   <= day_number_in;
		end
		if (en2 && v1_q) op_s2 <= est_d;
		if (en3 && v2_q) op_s3 <= base_d;
		if (eno && v3_q) res_q <= fin_d;
	end

	assign rsp_valid      = vo_q;
	assign day_number_out = res_q.day_number;
	assign year_out       = res_q.year;
	assign month_out      = res_q.month;
	assign day_out        = res_q.day;
	assign valid_res      = res_q.valid;

	// an accepted item always lands in the first stage
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> v1_q)
		else $error("accepted item lost at first stage");

	// a full stage that cannot move keeps its item
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && !en3 |=> v3_q && $stable(op_s3))
		else $error("stalled stage 3 item changed");

	// a day number result carries no date
	a_dn_no_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && day_number_out != '0 |->
			year_out == '0 && month_out == '0 && day_out == '0)
		else $error("date fields set on a day number result");

	// an undefined result carries no date
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !valid_res |->
			year_out == '0 && month_out == '0 && day_out == '0)
		else $error("date fields set on an invalid result");

	// a decoded date has a real month and a nonzero day
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && valid_res && month_out != '0 |->
			month_out <= MONTH_W'(12) && day_out != '0)
		else $error("decoded date out of range");

endmodule
